// ===== hdl/lifet_pkg.sv =====
// ----------------------------------------------------------------------------
// lifet_pkg
// Shared types and constants of the toroidal life grid block.
// ----------------------------------------------------------------------------
package lifet_pkg;

  // Wide enough for any grid size up to 256, more than the 7-bit size registers can hold.
  localparam int SIZE_W = 9;

  // Input item operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Reset value of both size registers.
  localparam logic [6:0] SIZE_RESET = 7'd64;

  // Life rule neighbor counts.
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  // Depth of the command queue between front and back.
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_READ_ZERO,
    CMD_STEP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [5:0] row;
    logic [5:0] col;
    logic       alive;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_SWEEP
  } eng_state_t;

endpackage

// ===== hdl/lifet_ifs.sv =====
// ----------------------------------------------------------------------------
// lifet channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface lifet_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] col;
  logic [5:0] row;
  logic       alive_in;

  modport source (output valid, operation, col, row, alive_in, input ready);
  modport sink (input valid, operation, col, row, alive_in, output ready);
endinterface

interface lifet_rsp_if;
  logic valid;
  logic ready;
  logic alive_out;

  modport source (output valid, alive_out, input ready);
  modport sink (input valid, alive_out, output ready);
endinterface

// ===== hdl/life_automaton_torus_step.sv =====
// ----------------------------------------------------------------------------
// life_automaton_torus_step
// Toroidal Game of Life grid with cell write, cell read and generation step.
// ----------------------------------------------------------------------------
//
//  Channel  Dir   Handshake                         Payload
//  -------  ----  --------------------------------  ----------------------------
//  req      in    valid & ready at rising edge      operation, col, row, alive_in
//  rsp      out   valid & ready at rising edge      alive_out
//  APB      in    psel & penable & pwrite & pready  paddr, pwdata (prdata out)
//
//  A write item and a read inside the area pass through the engine's cell
//  state, a read outside it is answered straight from idle, and a step runs
//  a sweep that reads one row per cycle from the single read port of the
//  grid memory, plus window fill and drain. Reset (rst, synchronous, active
//  high) clears the grid to all dead through per-row valid bits, with no
//  clearing pass. A stalled result holds in the output register while the
//  front keeps accepting items into the two-entry command queue.
//
module life_automaton_torus_step
  import lifet_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  lifet_req_if.sink   req,
  lifet_rsp_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]        grid_width;
  logic [6:0]        grid_height;
  logic [SIZE_W-1:0] used_width;
  logic [SIZE_W-1:0] used_height;
  logic              cfg_write;

  logic              queue_full;
  logic              push;
  cmd_t              push_cmd;
  logic              pop;
  logic              head_valid;
  cmd_t              head;

  // Configuration registers. The register index is address bit 2.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_RESET;
      grid_height <= SIZE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_GRID_WIDTH) begin
        grid_width <= pwdata[6:0];
      end else begin
        grid_height <= pwdata[6:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? {25'd0, grid_height} : {25'd0, grid_width};

  // Sizes in use: zero acts as one, anything above the maximum acts as the maximum.
  always_comb begin
    if (grid_width == '0) begin
      used_width = SIZE_W'(1);
    end else if (SIZE_W'(grid_width) > SIZE_W'(MAX_COLS)) begin
      used_width = SIZE_W'(MAX_COLS);
    end else begin
      used_width = SIZE_W'(grid_width);
    end
    if (grid_height == '0) begin
      used_height = SIZE_W'(1);
    end else if (SIZE_W'(grid_height) > SIZE_W'(MAX_ROWS)) begin
      used_height = SIZE_W'(MAX_ROWS);
    end else begin
      used_height = SIZE_W'(grid_height);
    end
  end

  // The front classifies each item: out-of-area writes and unused codes are
  // dropped, out-of-area reads become a command that answers zero.
  lifet_front u_front (
    .rst         (rst),
    .used_width  (used_width),
    .used_height (used_height),
    .req         (req),
    .queue_full  (queue_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  lifet_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // The engine owns the grid memory and runs one command at a time.
  lifet_engine #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .used_width  (used_width),
    .used_height (used_height),
    .cmd_valid   (head_valid),
    .cmd         (head),
    .pop         (pop),
    .rsp         (rsp)
  );

endmodule

// ===== hdl/lifet_front.sv =====
// ----------------------------------------------------------------------------
// lifet_front
// Accepts input items, checks coordinates and turns them into commands.
// ----------------------------------------------------------------------------
module lifet_front
  import lifet_pkg::*;
(
  input  logic              rst,
  input  logic [SIZE_W-1:0] used_width,
  input  logic [SIZE_W-1:0] used_height,
  lifet_req_if.sink         req,
  input  logic              queue_full,
  output logic              push,
  output cmd_t              push_cmd
);

  logic in_area;
  logic keep;

  // Items flow straight through to the queue; ready drops while it is full or in reset.
  assign req.ready = !queue_full && !rst;

  assign in_area = (SIZE_W'(req.col) < used_width) && (SIZE_W'(req.row) < used_height);

  always_comb begin
    keep          = 1'b0;
    push_cmd.kind = CMD_STEP;
    push_cmd.row  = req.row;
    push_cmd.col  = req.col;
    push_cmd.alive = req.alive_in;
    unique case (req.operation)
      OP_WRITE: begin
        keep          = in_area;
        push_cmd.kind = CMD_WRITE;
      end
      OP_READ: begin
        keep          = 1'b1;
        push_cmd.kind = in_area ? CMD_READ : CMD_READ_ZERO;
      end
      OP_STEP: begin
        keep          = 1'b1;
        push_cmd.kind = CMD_STEP;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = req.valid && req.ready && keep;

endmodule

// ===== hdl/lifet_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lifet_cmd_fifo
// Short command queue that decouples the front from the grid engine.
// ----------------------------------------------------------------------------
module lifet_cmd_fifo
  import lifet_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int NW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          entries [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == NW'(CMDQ_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lifet_engine.sv =====
// ----------------------------------------------------------------------------
// lifet_engine
// Grid memory, cell read/write and the row-by-row generation sweep.
// ----------------------------------------------------------------------------
module lifet_engine
  import lifet_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] used_width,
  input  logic [SIZE_W-1:0] used_height,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              pop,
  lifet_rsp_if.source       rsp
);

  localparam int CA = $clog2(MAX_COLS);
  localparam int RA = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 4);
  localparam int XW = SIZE_W + 1;
  // Cycles from the first sweep read until the window holds a complete row set.
  localparam int FILL_CYCLES = 4;

  typedef logic [MAX_COLS-1:0] row_t;

  row_t          grid_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid;
  row_t          rd_data;
  logic          rd_valid;
  row_t          rd_eff;

  eng_state_t    state;
  eng_state_t    state_next;
  cmd_t          cur;
  logic [CW-1:0] cyc;
  row_t          win0;
  row_t          win1;
  row_t          win2;
  row_t          first_row;
  logic          out_valid;
  logic          out_alive;

  logic          out_load;
  logic          out_bit;
  logic [RA-1:0] rd_addr;
  logic          wr_en;
  logic [RA-1:0] wr_addr;
  row_t          wr_data;
  logic          shift_rd;
  logic          shift_first;
  logic          grab_first;

  logic [XW-1:0] cx;
  logic [XW-1:0] hx;
  logic [CA-1:0] wm1;
  row_t          next_row;
  row_t          cell_row;

  assign cx     = XW'(cyc);
  assign hx     = XW'(used_height);
  assign wm1    = CA'(used_width - 1'b1);
  assign rd_eff = rd_valid ? rd_data : '0;

  // Next generation of the window's middle row.
  always_comb begin
    row_t       l0, l1, l2, r0, r1, r2;
    logic [3:0] n;
    l0 = {win0[MAX_COLS-2:0], win0[MAX_COLS-1]};
    l1 = {win1[MAX_COLS-2:0], win1[MAX_COLS-1]};
    l2 = {win2[MAX_COLS-2:0], win2[MAX_COLS-1]};
    r0 = {win0[0], win0[MAX_COLS-1:1]};
    r1 = {win1[0], win1[MAX_COLS-1:1]};
    r2 = {win2[0], win2[MAX_COLS-1:1]};
    l0[0] = win0[wm1];
    l1[0] = win1[wm1];
    l2[0] = win2[wm1];
    n = '0;
    next_row = win1;
    for (int c = 0; c < MAX_COLS; c++) begin
      if (CA'(c) == wm1) begin
        r0[c] = win0[0];
        r1[c] = win1[0];
        r2[c] = win2[0];
      end
      n = 4'(l0[c]) + 4'(win0[c]) + 4'(r0[c]) + 4'(l1[c]) + 4'(r1[c]) +
          4'(l2[c]) + 4'(win2[c]) + 4'(r2[c]);
      if (SIZE_W'(c) < used_width) begin
        next_row[c] = (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && win1[c]);
      end
    end
  end

  always_comb begin
    cell_row = rd_eff;
    cell_row[CA'(cur.col)] = cur.alive;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_STEP:      state_next = ST_SWEEP;
            CMD_WRITE:     state_next = ST_CELL;
            CMD_READ:      state_next = out_valid ? ST_IDLE : ST_CELL;
            CMD_READ_ZERO: state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_CELL:  state_next = ST_IDLE;
      ST_SWEEP: state_next = (cx == hx + XW'(3)) ? ST_IDLE : ST_SWEEP;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    pop         = 1'b0;
    out_load    = 1'b0;
    out_bit     = 1'b0;
    rd_addr     = RA'(cmd.row);
    wr_en       = 1'b0;
    wr_addr     = RA'(cur.row);
    wr_data     = cell_row;
    shift_rd    = 1'b0;
    shift_first = 1'b0;
    grab_first  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_STEP, CMD_WRITE: pop = 1'b1;
            CMD_READ:            pop = !out_valid;
            CMD_READ_ZERO: begin
              pop      = !out_valid;
              out_load = !out_valid;
            end
            default: pop = 1'b0;
          endcase
        end
      end
      ST_CELL: begin
        if (cur.kind == CMD_WRITE) begin
          wr_en = 1'b1;
        end else begin
          out_load = 1'b1;
          out_bit  = rd_eff[CA'(cur.col)];
        end
      end
      ST_SWEEP: begin
        rd_addr     = (cyc == '0) ? RA'(used_height - 1'b1) : RA'(cyc - 1'b1);
        shift_rd    = (cx >= XW'(1)) && (cx <= hx + XW'(1));
        shift_first = (cx == hx + XW'(2));
        grab_first  = (cx == XW'(2));
        wr_en       = (cx >= XW'(FILL_CYCLES));
        wr_addr     = RA'(cyc - CW'(FILL_CYCLES));
        wr_data     = next_row;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Grid memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    rd_data <= grid_mem[rd_addr];
  end

  // Rows never written since reset read as all dead.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_valid <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= cmd;
    end
    if (shift_rd || shift_first) begin
      win0 <= win1;
      win1 <= win2;
      win2 <= shift_first ? first_row : rd_eff;
    end
    if (grab_first) begin
      first_row <= rd_eff;
    end
    if (out_load) begin
      out_alive <= out_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cyc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cyc   <= (state == ST_SWEEP) ? cyc + 1'b1 : '0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.alive_out = out_alive;

endmodule

// ===== tb/sv/life_automaton_torus_step_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_automaton_torus_step_tb
// Self-checking testbench for the toroidal life grid block. A behavioral copy
// of the grid predicts every read, and random handshake gaps run on both
// channels while the grid size is changed between phases over the APB port.
// ----------------------------------------------------------------------------
module life_automaton_torus_step_tb
  import lifet_pkg::*;
();

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_GAP      = 13;
  localparam int DIM          = 64;
  // A step sweeps every grid row in the engine and two more items can sit in
  // the command queue, so this covers anything still in flight after the last
  // read has come back.
  localparam int SETTLE_CYCLES = 260;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_ITEMS   = 24;
  localparam int REPORT_LIMIT  = 10;
  // The one operation code the block leaves unused.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lifet_req_if req ();
  lifet_rsp_if rsp ();

  life_automaton_torus_step dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Behavioral copy of the grid: life_cells[row][col], plus the two size
  // registers exactly as written (the saturation is applied on use).
  logic [DIM-1:0] life_cells [DIM];
  logic [6:0]     width_reg;
  logic [6:0]     height_reg;

  // Cell values that pending reads must return, oldest first.
  bit expected_alive [$];

  int  mismatch_count;
  int  items_sent;
  int  cycle_count;
  bit  calm_sender;
  bit  calm_receiver;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // A hang anywhere (a lost read, a stuck ready) ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("life_automaton_torus_step test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------------

  // A size of zero behaves as one and anything past the array as the array.
  function automatic int effective_size(input logic [6:0] value);
    if (value == 7'd0) return 1;
    if (value > DIM) return DIM;
    return int'(value);
  endfunction

  // Every cell of the active area looks at its eight wrapped neighbors in the
  // grid as it stood before the step. On tiny areas a neighbor position can
  // land on the same cell more than once, or on the cell itself, and each
  // position still counts. Cells outside the area are left alone.
  function automatic void advance_generation(input int w, input int h);
    logic [DIM-1:0] prior [DIM];
    int rm;
    int rp;
    int cm;
    int cp;
    int n;
    prior = life_cells;
    for (int r = 0; r < h; r++) begin
      rm = (r == 0) ? h - 1 : r - 1;
      rp = (r + 1 == h) ? 0 : r + 1;
      for (int c = 0; c < w; c++) begin
        cm = (c == 0) ? w - 1 : c - 1;
        cp = (c + 1 == w) ? 0 : c + 1;
        n = int'(prior[rm][cm]) + int'(prior[rm][c]) + int'(prior[rm][cp]) +
            int'(prior[r][cm]) + int'(prior[r][cp]) +
            int'(prior[rp][cm]) + int'(prior[rp][c]) + int'(prior[rp][cp]);
        if (n == BIRTH_COUNT)
          life_cells[r][c] = 1'b1;
        else if (n == KEEP_COUNT)
          life_cells[r][c] = prior[r][c];
        else
          life_cells[r][c] = 1'b0;
      end
    end
  endfunction

  // Applies one accepted item to the predicted grid. A read of a cell outside
  // the area still produces a result, and that result is always dead.
  function automatic void apply_to_grid(input logic [1:0] op, input logic [5:0] col,
                                        input logic [5:0] row, input logic alive);
    int w;
    int h;
    bit in_area;
    w = effective_size(width_reg);
    h = effective_size(height_reg);
    in_area = (col < w) && (row < h);
    case (op)
      OP_WRITE: if (in_area) life_cells[row][col] = alive;
      OP_READ:  expected_alive.push_back(in_area ? life_cells[row][col] : 1'b0);
      OP_STEP:  advance_generation(w, h);
      default:  ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls on ready, and the comparison of each result.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = calm_receiver ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (expected_alive.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result with no read pending, alive_out=%b", $realtime,
                   rsp.alive_out);
      end else if (rsp.alive_out !== expected_alive[0]) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: alive_out mismatch, expected %b, got %b", $realtime,
                   expected_alive[0], rsp.alive_out);
        void'(expected_alive.pop_front());
      end else begin
        void'(expected_alive.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item, register and pause tasks
  // ---------------------------------------------------------------------------

  // Sends one item after a random gap. The task returns at the edge where the
  // item was taken with valid still high, so a following item with no gap
  // keeps valid up without a drop in between.
  task automatic send_item(input logic [1:0] op, input logic [5:0] col,
                           input logic [5:0] row, input logic alive);
    int gap;
    gap = calm_sender ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.col       <= col;
    req.row       <= row;
    req.alive_in  <= alive;
    do @(posedge clk); while (req.ready !== 1'b1);
    apply_to_grid(op, col, row, alive);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Holds the sender back until every read has returned. At least one edge
  // always passes, so valid is never lowered and raised in one time step.
  task automatic wait_for_results();
    req.valid <= 1'b0;
    do @(posedge clk); while (expected_alive.size() != 0);
  endtask

  // One APB write: a setup cycle, then the access cycle that completes on the
  // first edge with pready high. Bits above the 7-bit register are random and
  // must be dropped by the block.
  task automatic write_register(input logic index, input logic [6:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {25'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == REG_GRID_WIDTH)
      width_reg = value;
    else
      height_reg = value;
  endtask

  // The size only changes with the block idle: all reads back, and enough
  // time for queued writes and steps to finish in the engine.
  task automatic resize_grid(input logic [6:0] w, input logic [6:0] h);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(REG_GRID_WIDTH, w);
    write_register(REG_GRID_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset must leave the whole grid dead, checked at three of its corners.
  task automatic test_reset_contents();
    send_item(OP_READ, 6'd0, 6'd0, 1'b0);
    send_item(OP_READ, 6'd63, 6'd63, 1'b1);
    send_item(OP_READ, 6'd63, 6'd0, 1'b0);
  endtask

  // Writes and reads at the coordinate extremes, a write of a dead cell over
  // a live one, and the unused operation code with every field bit set, which
  // must change nothing and return nothing.
  task automatic test_cell_access();
    send_item(OP_WRITE, 6'd0, 6'd0, 1'b1);
    send_item(OP_WRITE, 6'd63, 6'd63, 1'b1);
    send_item(OP_WRITE, 6'd63, 6'd0, 1'b1);
    send_item(OP_READ, 6'd0, 6'd0, 1'b0);
    send_item(OP_READ, 6'd63, 6'd63, 1'b0);
    send_item(OP_WRITE, 6'd63, 6'd63, 1'b0);
    send_item(OP_READ, 6'd63, 6'd63, 1'b0);
    send_item(OP_UNUSED, 6'd63, 6'd63, 1'b1);
    send_item(OP_READ, 6'd63, 6'd63, 1'b0);
  endtask

  // A horizontal blinker that straddles the column wrap must turn vertical
  // around column 0. The lone cells left from the access test die.
  task automatic test_wrap_blinker();
    send_item(OP_WRITE, 6'd63, 6'd20, 1'b1);
    send_item(OP_WRITE, 6'd0, 6'd20, 1'b1);
    send_item(OP_WRITE, 6'd1, 6'd20, 1'b1);
    send_item(OP_STEP, 6'd0, 6'd0, 1'b0);
    send_item(OP_READ, 6'd0, 6'd19, 1'b0);
    send_item(OP_READ, 6'd0, 6'd21, 1'b0);
    send_item(OP_READ, 6'd63, 6'd20, 1'b0);
    wait_for_results();
  endtask

  // A width of zero acts as one column. Writes past the area are ignored and
  // reads past it return dead, and the single column wraps onto itself during a step.
  task automatic test_degenerate_sizes();
    resize_grid(7'd0, 7'd2);
    send_item(OP_WRITE, 6'd5, 6'd0, 1'b1);
    send_item(OP_READ, 6'd5, 6'd1, 1'b1);
    send_item(OP_WRITE, 6'd0, 6'd0, 1'b1);
    send_item(OP_STEP, 6'd0, 6'd0, 1'b0);
    send_item(OP_READ, 6'd0, 6'd0, 1'b0);
    send_item(OP_READ, 6'd0, 6'd1, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random tests
  // ---------------------------------------------------------------------------

  // A well-formed sequence: seed a 3x3 patch (wrapped) at a random spot, step
  // a few generations, and read cells around the patch after each step.
  task automatic seed_and_evolve(input int w, input int h);
    int base_c;
    int base_r;
    int gens;
    int probes;
    base_c = $urandom_range(0, w - 1);
    base_r = $urandom_range(0, h - 1);
    for (int dr = 0; dr < 3; dr++)
      for (int dc = 0; dc < 3; dc++)
        if ($urandom_range(0, 3) != 0)
          send_item(OP_WRITE, 6'((base_c + dc) % w), 6'((base_r + dr) % h),
                    $urandom_range(0, 2) != 0);
    gens = $urandom_range(1, 3);
    for (int g = 0; g < gens; g++) begin
      send_item(OP_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
      probes = $urandom_range(1, 4);
      for (int p = 0; p < probes; p++)
        send_item(OP_READ, 6'((base_c + $urandom_range(0, 4) + w - 1) % w),
                  6'((base_r + $urandom_range(0, 4) + h - 1) % h), 1'($urandom));
    end
  endtask

  // Noise: any operation code, and coordinates anywhere in the 64x64 space,
  // so small areas see plenty of accesses outside their bounds.
  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic run_random_phase(input logic [6:0] w_set, input logic [6:0] h_set);
    int w;
    int h;
    int goal;
    resize_grid(w_set, h_set);
    w = effective_size(width_reg);
    h = effective_size(height_reg);
    calm_sender   = ($urandom_range(0, 3) == 0);
    calm_receiver = ($urandom_range(0, 3) == 0);
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 9) < 7)
        seed_and_evolve(w, h);
      else
        send_noise();
      if ($urandom_range(0, 19) == 0)
        wait_for_results();
    end
    calm_sender   = 1'b0;
    calm_receiver = 1'b0;
  endtask

  // Sizes run from a single cell through thin strips to the full grid, with
  // zero and oversized values among them. A small area followed by the full
  // one shows that cells outside the area kept their values.
  task automatic test_random_phases();
    run_random_phase(7'd1, 7'd1);
    run_random_phase(7'd2, 7'd2);
    run_random_phase(7'd0, 7'd3);
    run_random_phase(7'd2, 7'd1);
    run_random_phase(7'd3, 7'd3);
    run_random_phase(7'd64, 7'd1);
    run_random_phase(7'd1, 7'd64);
    run_random_phase(7'd127, 7'd0);
    run_random_phase(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
    run_random_phase(7'd65, 7'd70);
    run_random_phase(7'd8, 7'd8);
    run_random_phase(7'd64, 7'd64);
    run_random_phase(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.operation <= OP_WRITE;
    req.col       <= 6'd0;
    req.row       <= 6'd0;
    req.alive_in  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= 3'd0;
    pwdata        <= 32'd0;

    for (int r = 0; r < DIM; r++) life_cells[r] = '0;
    width_reg      = SIZE_RESET;
    height_reg     = SIZE_RESET;
    mismatch_count = 0;
    items_sent     = 0;
    cycle_count    = 0;
    calm_sender    = 1'b0;
    calm_receiver  = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_contents();
    test_cell_access();
    test_wrap_blinker();
    test_degenerate_sizes();
    test_random_phases();

    // Drain: every read back, then time for anything still in the engine to
    // show up as an unexpected result.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("life_automaton_torus_step test passed");
    else
      $display("life_automaton_torus_step test failed");
    $finish;
  end

endmodule
